FILE: rtl/rbf_adaptive_estimator_top_defines.svh
// Assertion macros for the estimator's checker file.
`ifndef RBF_ADAPTIVE_ESTIMATOR_TOP_DEFINES_SVH
`define RBF_ADAPTIVE_ESTIMATOR_TOP_DEFINES_SVH

// Antecedent in one cycle, consequent in the next; off while in reset.
`define RBFAE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// What must hold in the cycle after reset is sampled.
`define RBFAE_ASSERT_RESET(lbl, clk, rst_n, cons, msg) \
    lbl: assert property (@(posedge clk) (!rst_n) |=> (cons)) else $error(msg);

`endif

FILE: rtl/rbfae_pkg.sv
// Types, codes and constants of the RBF adaptive estimator.
`default_nettype none
package rbfae_pkg;
    localparam int DATA_W      = 24;
    localparam int DIMS        = 6;
    localparam int OUTS        = 3;
    localparam int CFG_W       = 24;
    localparam int CFG_IDX_W   = 2;
    localparam int KIND_W      = 2;
    localparam int IDX_W       = 6;
    localparam int DT_W        = 16;
    localparam int EST_W       = 32;
    localparam int IN_TDATA_W  = 240;
    localparam int OUT_TDATA_W = 96;
    localparam int ERR_BASE    = IDX_W + DIMS * DATA_W;
    localparam int DT_BASE     = ERR_BASE + OUTS * DATA_W;

    localparam logic [CFG_IDX_W-1:0] CFG_RATE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEAK  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH = 2'd2;

    localparam logic [CFG_W-1:0] RATE_RST  = 24'd65536;
    localparam logic [CFG_W-1:0] LEAK_RST  = 24'd6554;
    localparam logic [CFG_W-1:0] WIDTH_RST = 24'd65536;

    localparam logic [KIND_W-1:0] KIND_EST   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

    localparam logic signed [48:0] WEIGHT_LIM = 49'sd3276800;
    localparam logic signed [59:0] DQ_LIM     = 60'sd274877906944;

    typedef logic signed [DATA_W-1:0] t_word;
    typedef t_word [DIMS-1:0] t_vec;
    typedef t_word [OUTS-1:0] t_wts;

    typedef struct packed {
        logic shift;
        logic clear;
    } t_cell_ctl;

    // exp(-2^k) in Q0.32, k = -16 .. 3
    localparam logic [31:0] EXP_TAB [20] = '{
        32'd4294901760, 32'd4294836226, 32'd4294705160, 32'd4294443040,
        32'd4293918848, 32'd4292870656, 32'd4290775039, 32'd4286586875,
        32'd4278222805, 32'd4261543595, 32'd4228380000, 32'd4162825044,
        32'd4034748382, 32'd3790295335, 32'd3344923893, 32'd2605029347,
        32'd1580030169, 32'd581260616,  32'd78665070,   32'd1440801
    };
endpackage
`default_nettype wire

FILE: rtl/rbfae_cell.sv
// One neuron cell of the ring: its centre and its three output weights.
`default_nettype none
module rbfae_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rbfae_pkg::t_cell_ctl i_ctl,
    input  logic                 i_load,
    input  rbfae_pkg::t_vec      i_load_c,
    input  rbfae_pkg::t_vec      i_nxt_c,
    input  rbfae_pkg::t_wts      i_nxt_w,
    output rbfae_pkg::t_vec      o_c,
    output rbfae_pkg::t_wts      o_w
);
    import rbfae_pkg::*;

    t_vec r_c;
    t_wts r_w;

    // centre has no reset value
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_c <= i_load_c;
        end else if (i_ctl.shift) begin
            r_c <= i_nxt_c;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w <= '0;
        end else if (i_ctl.clear) begin
            r_w <= '0;
        end else if (i_ctl.shift) begin
            r_w <= i_nxt_w;
        end
    end

    assign o_c = r_c;
    assign o_w = r_w;
endmodule
`default_nettype wire

FILE: rtl/rbf_adaptive_estimator_top.sv
// Top level of the Gaussian RBF estimator with online weight adaptation.
// Use:
//   Input words arrive on s_axis_*; tuser carries the kind (estimate, load
//   centre, clear weights), tdata the index, vector, error and time step.
//   An estimate word yields one result word on m_axis_* (est_x/y/z, Q15.16);
//   load and clear words yield none. Registers are written on i_cfg_*;
//   the user must write them only while the block is idle (not enforced).
// Sequence:
//   One word at a time. Load, clear and ignored kinds go from S_DISP back
//   to idle. An estimate runs, for each neuron, the bit-serial divider and
//   the exp product walk, then the weight update; the divider and the walk
//   are skipped when the neuron is far enough that its basis value is zero.
//   The neurons live in a ring of cells that rotates one place per neuron,
//   so the head cell always feeds the datapath.
// Reset:
//   Synchronous, active low: weights clear to zero, registers take their
//   defaults, the output is emptied. Centres must be loaded before use.
// Stall:
//   The result sits in an output register until taken; a new word is
//   accepted meanwhile, but the next result waits for the slot to drain.
`default_nettype none
module rbf_adaptive_estimator_top #(
    parameter int NEURONS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [rbfae_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [rbfae_pkg::CFG_W-1:0]        i_cfg_data,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // neuron_index, vec_a..vec_f, err_x, err_y, err_z, step_time, 2 pad bits
    input  logic [rbfae_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // kind
    input  logic [rbfae_pkg::KIND_W-1:0]       s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // est_x, est_y, est_z
    output logic [rbfae_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
    import rbfae_pkg::*;

    localparam int NW = (NEURONS > 1) ? $clog2(NEURONS) : 1;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DISP  = 4'd1;
    localparam logic [3:0] S_DEN   = 4'd2;
    localparam logic [3:0] S_ESQ   = 4'd3;
    localparam logic [3:0] S_SQRT  = 4'd4;
    localparam logic [3:0] S_EN    = 4'd5;
    localparam logic [3:0] S_SQ    = 4'd6;
    localparam logic [3:0] S_CHK   = 4'd7;
    localparam logic [3:0] S_DIV   = 4'd8;
    localparam logic [3:0] S_EXP   = 4'd9;
    localparam logic [3:0] S_H     = 4'd10;
    localparam logic [3:0] S_EST   = 4'd11;
    localparam logic [3:0] S_UPD   = 4'd12;
    localparam logic [3:0] S_SHIFT = 4'd13;
    localparam logic [3:0] S_DONE  = 4'd14;

    logic [3:0] r_state, n_state;
    logic [CFG_W-1:0] r_rate, r_leak, r_width;
    logic r_mv;
    logic [OUT_TDATA_W-1:0] r_mdata;

    // item registers
    t_vec              r_z;
    t_wts              r_e;
    logic [DT_W-1:0]   r_dt;
    logic [KIND_W-1:0] r_kind;
    logic [IDX_W-1:0]  r_idx;

    // datapath registers
    logic [4:0]         r_cnt;
    logic [1:0]         r_j;
    logic [2:0]         r_ph;
    logic [NW-1:0]      r_n;
    logic [48:0]        r_den;
    logic [47:0]        r_esq, r_sn, r_root, r_bit;
    logic [33:0]        r_en;
    logic [50:0]        r_s;
    logic [53:0]        r_rem;
    logic [19:0]        r_x;
    logic [32:0]        r_acc;
    logic [16:0]        r_h;
    logic signed [45:0] r_sum [OUTS];
    logic signed [41:0] r_p1;
    logic signed [58:0] r_p2;
    logic signed [39:0] r_dq;
    logic signed [47:0] r_g, r_del;
    t_wts               r_wn;

    // ring
    t_vec      w_c [NEURONS];
    t_wts      w_w [NEURONS];
    t_cell_ctl w_ctl;
    logic [NEURONS-1:0] w_load;

    wire accept = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_mv;
    assign m_axis_tdata  = r_mdata;

    assign w_ctl.shift = (r_state == S_SHIFT);
    assign w_ctl.clear = (r_state == S_DISP) && (r_kind == KIND_CLEAR);

    genvar k;
    generate
        for (k = 0; k < NEURONS; k++) begin : g_ring
            t_vec nxt_c;
            t_wts nxt_w;
            if (k == NEURONS - 1) begin : g_tail
                // tail takes the head's centre and its adapted weights
                assign nxt_c = w_c[0];
                assign nxt_w = r_wn;
            end else begin : g_mid
                assign nxt_c = w_c[k+1];
                assign nxt_w = w_w[k+1];
            end
            assign w_load[k] = (r_state == S_DISP) && (r_kind == KIND_LOAD) &&
                               (r_idx == IDX_W'(k));
            rbfae_cell u_cell (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_ctl    (w_ctl),
                .i_load   (w_load[k]),
                .i_load_c (r_z),
                .i_nxt_c  (nxt_c),
                .i_nxt_w  (nxt_w),
                .o_c      (w_c[k]),
                .o_w      (w_w[k])
            );
        end
    endgenerate

    // combinational helpers
    logic [CFG_W-1:0]   c_w0;
    logic [47:0]        c_ww;
    logic signed [47:0] c_esq;
    logic [47:0]        c_st;
    logic               c_sge;
    logic [48:0]        c_enp;
    logic signed [24:0] c_diff;
    logic signed [49:0] c_sq;
    logic               c_big;
    logic [53:0]        c_d8;
    logic               c_ge;
    logic [53:0]        c_rsub;
    logic [64:0]        c_psum;
    logic [32:0]        c_hs;
    t_word              c_wj, c_ej;
    logic signed [41:0] c_wh;
    logic signed [59:0] c_dif, c_dr;
    logic signed [64:0] c_gp, c_dp;
    logic signed [48:0] c_ws;
    logic signed [45:0] c_est [OUTS];
    logic [OUT_TDATA_W-1:0] c_out;

    always_comb begin
        c_w0   = (r_width == '0) ? CFG_W'(1) : r_width;
        c_ww   = c_w0 * c_w0;
        c_ej   = r_e[r_cnt[1:0]];
        c_esq  = $signed(c_ej) * $signed(c_ej);
        c_st   = r_root + r_bit;
        c_sge  = (r_sn >= c_st);
        c_enp  = r_leak * r_root[24:0];
        c_diff = $signed({r_z[r_cnt[2:0]][DATA_W-1], r_z[r_cnt[2:0]]}) -
                 $signed({w_c[0][r_cnt[2:0]][DATA_W-1], w_c[0][r_cnt[2:0]]});
        c_sq   = c_diff * c_diff;
        c_big  = ({2'b00, r_s} >= {r_den, 4'b0000});
        c_d8   = {2'b00, r_den, 3'b000};
        c_ge   = (r_rem >= c_d8);
        c_rsub = c_ge ? (r_rem - c_d8) : r_rem;
        c_psum = (r_acc * EXP_TAB[r_cnt]) + {33'd0, 1'b1, 31'd0};
        c_hs   = r_acc + 33'd32768;
        c_wj   = w_w[0][r_j];
        c_ej   = r_e[r_j];
        if (r_state == S_ESQ) begin
            c_ej = r_e[r_cnt[1:0]];
        end
        c_wh   = $signed(c_wj) * $signed({1'b0, r_h});
        c_dif  = 60'(r_p1) - 60'(r_p2);
        c_dr   = (c_dif + 60'sd32768) >>> 16;
        c_gp   = r_dq * $signed({1'b0, r_rate});
        c_dp   = r_g * $signed({1'b0, r_dt});
        c_ws   = 49'(c_wj) + 49'(r_del);
        for (int j = 0; j < OUTS; j++) begin
            c_est[j] = (r_sum[j] + 46'sd32768) >>> 16;
            // the sum cannot leave the 32-bit range at NEURONS <= 64
            c_out[j*EST_W +: EST_W] = c_est[j][EST_W-1:0];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (accept) n_state = S_DISP;
            S_DISP:  n_state = (r_kind == KIND_EST) ? S_DEN : S_IDLE;
            S_DEN:   n_state = S_ESQ;
            S_ESQ:   if (r_cnt == 5'd2) n_state = S_SQRT;
            S_SQRT:  if (r_cnt == 5'd23) n_state = S_EN;
            S_EN:    n_state = S_SQ;
            S_SQ:    if (r_cnt == 5'd5) n_state = S_CHK;
            S_CHK:   n_state = c_big ? S_EST : S_DIV;
            S_DIV:   if (r_cnt == 5'd19) n_state = S_EXP;
            S_EXP:   if (r_cnt == 5'd19) n_state = S_H;
            S_H:     n_state = S_EST;
            S_EST:   if (r_j == 2'd2) n_state = S_UPD;
            S_UPD:   if (r_ph == 3'd5 && r_j == 2'd2) n_state = S_SHIFT;
            S_SHIFT: n_state = (r_n == NW'(NEURONS - 1)) ? S_DONE : S_SQ;
            S_DONE:  if (!r_mv || m_axis_tready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control, registers and output slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rate  <= RATE_RST;
            r_leak  <= LEAK_RST;
            r_width <= WIDTH_RST;
            r_mv    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_RATE:  r_rate  <= i_cfg_data;
                    CFG_LEAK:  r_leak  <= i_cfg_data;
                    CFG_WIDTH: r_width <= i_cfg_data;
                    default:   ;
                endcase
            end
            if (r_state == S_DONE && (!r_mv || m_axis_tready)) begin
                r_mv <= 1'b1;
            end else if (m_axis_tready) begin
                r_mv <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && (!r_mv || m_axis_tready)) begin
            r_mdata <= c_out;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_cnt <= (n_state != r_state) ? 5'd0 : r_cnt + 5'd1;
        if (n_state != r_state) begin
            r_j  <= 2'd0;
            r_ph <= 3'd0;
        end
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    r_kind <= s_axis_tuser;
                    r_idx  <= s_axis_tdata[IDX_W-1:0];
                    for (int i = 0; i < DIMS; i++) begin
                        r_z[i] <= s_axis_tdata[IDX_W + i*DATA_W +: DATA_W];
                    end
                    for (int j = 0; j < OUTS; j++) begin
                        r_e[j] <= s_axis_tdata[ERR_BASE + j*DATA_W +: DATA_W];
                    end
                    r_dt <= s_axis_tdata[DT_BASE +: DT_W];
                end
            end
            S_DEN: begin
                r_den <= {c_ww, 1'b0};
                r_esq <= '0;
                for (int j = 0; j < OUTS; j++) begin
                    r_sum[j] <= '0;
                end
            end
            S_ESQ: begin
                r_esq  <= r_esq + 48'(c_esq);
                r_sn   <= r_esq + 48'(c_esq);
                r_root <= '0;
                r_bit  <= 48'd1 << 46;
            end
            S_SQRT: begin
                if (c_sge) begin
                    r_sn   <= r_sn - c_st;
                    r_root <= (r_root >> 1) + r_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            S_EN: begin
                r_en <= 34'((c_enp + 49'd32768) >> 16);
                r_n  <= '0;
                r_s  <= '0;
            end
            S_SQ: begin
                r_s <= r_s + 51'(c_sq[47:0]);
            end
            S_CHK: begin
                r_h   <= '0;
                r_rem <= {3'b000, r_s};
                r_x   <= '0;
            end
            S_DIV: begin
                r_rem <= {c_rsub[52:0], 1'b0};
                r_x   <= {r_x[18:0], c_ge};
                r_acc <= 33'd1 << 32;
            end
            S_EXP: begin
                if (r_x[r_cnt]) begin
                    r_acc <= c_psum[64:32];
                end
            end
            S_H: begin
                r_h <= c_hs[32:16];
            end
            S_EST: begin
                r_sum[r_j] <= r_sum[r_j] + 46'(c_wh);
                if (n_state == r_state) begin
                    r_j <= r_j + 2'd1;
                end
            end
            S_UPD: begin
                case (r_ph)
                    3'd0: r_p1 <= $signed({1'b0, r_h}) * $signed(c_ej);
                    3'd1: r_p2 <= $signed({1'b0, r_en}) * $signed(c_wj);
                    3'd2: begin
                        if (c_dr > DQ_LIM) begin
                            r_dq <= 40'(DQ_LIM);
                        end else if (c_dr < -DQ_LIM) begin
                            r_dq <= 40'(-DQ_LIM);
                        end else begin
                            r_dq <= 40'(c_dr);
                        end
                    end
                    3'd3: r_g   <= 48'((c_gp + 65'sd32768) >>> 16);
                    3'd4: r_del <= 48'((c_dp + 65'sd32768) >>> 16);
                    default: begin
                        if (c_ws > WEIGHT_LIM) begin
                            r_wn[r_j] <= 24'(WEIGHT_LIM);
                        end else if (c_ws < -WEIGHT_LIM) begin
                            r_wn[r_j] <= 24'(-WEIGHT_LIM);
                        end else begin
                            r_wn[r_j] <= 24'(c_ws);
                        end
                    end
                endcase
                // on the last output the state change above clears the counters
                if (r_ph != 3'd5) begin
                    r_ph <= r_ph + 3'd1;
                end else if (n_state == r_state) begin
                    r_ph <= 3'd0;
                    r_j  <= r_j + 2'd1;
                end
            end
            S_SHIFT: begin
                r_n <= r_n + NW'(1);
                r_s <= '0;
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire

FILE: rtl/rbfae_checker.sv
// Port-level checks of the estimator, bound to its top level.
`default_nettype none
`include "rbf_adaptive_estimator_top_defines.svh"
module rbfae_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                s_axis_tvalid,
    input logic                                s_axis_tready,
    input logic                                m_axis_tvalid,
    input logic                                m_axis_tready,
    input logic [rbfae_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
    `RBFAE_ASSERT_RESET(a_rst_idle, i_clk, i_rst_n, !m_axis_tvalid && s_axis_tready, "not idle after reset")
    `RBFAE_ASSERT_NEXT(a_busy, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "ready stayed high after a word")
    `RBFAE_ASSERT_NEXT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")
endmodule

bind rbf_adaptive_estimator_top rbfae_checker u_rbfae_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
